FILE: sv/pidsp_pkg.sv
// Shared types, constants and microcode table of the PID speed-to-pedal controller.
package pidsp_pkg;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SCALE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_SCALE = 3'd5;

    // Register values after reset
    localparam logic signed [15:0] PROP_GAIN_RST   = 16'sd2089;
    localparam logic signed [15:0] INTEG_GAIN_RST  = 16'sd131;
    localparam logic signed [15:0] DERIV_GAIN_RST  = -16'sd1229;
    localparam logic [15:0]        STEP_PERIOD_RST = 16'd1229;
    localparam logic [15:0]        ACCEL_SCALE_RST = 16'd0;
    localparam logic [15:0]        BRAKE_SCALE_RST = 16'd0;

    // Datapath widths
    localparam int ERR_W  = 25;             // (desired - measured) * 256 / distance
    localparam int DLT_W  = ERR_W + 1;      // error minus previous error
    localparam int DVW    = DLT_W + 12;     // divider dividend width
    localparam int DVS_W  = 16;             // divider divisor width
    localparam int DER_W  = DVW;            // derivative term
    localparam int SUM_W  = 32;             // integral, PID and degree values
    localparam int ACC_W  = 55;             // sum of the three weighted terms
    localparam int MA_W   = 38;             // multiplier wide operand
    localparam int MB_W   = 24;             // multiplier narrow operand
    localparam int PROD_W = MA_W + MB_W;
    localparam int DIG_W  = 10;             // pedal value widened for digit split

    // Two quotient bits are produced per divider step
    localparam int DIV_STEPS = DVW / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // 180/pi in Q8.16
    localparam logic signed [MB_W-1:0] DEG_PER_RAD = 24'sd3754936;
    localparam int SAFE_BRAKE_RAW = 90;

    localparam logic [1:0] GEAR_PARK  = 2'd1;
    localparam logic [1:0] GEAR_DRIVE = 2'd2;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    // Operand pair presented to the shared multiplier
    typedef enum logic [2:0] {
        MS_NONE,
        MS_ERR_PER,
        MS_ERR_PG,
        MS_SUM_IG,
        MS_DER_DG,
        MS_PID_K,
        MS_DEG_SCL
    } mul_sel_t;

    // Division launched on the shared divider
    typedef enum logic [1:0] {
        DS_NONE,
        DS_ERR,
        DS_DER
    } div_sel_t;

    // Register written at the end of the step
    typedef enum logic [3:0] {
        WR_NONE,
        WR_ERR,
        WR_SUM,
        WR_ACC_LD,
        WR_ACC_ADD,
        WR_DER,
        WR_PID,
        WR_DEG,
        WR_PEDAL,
        WR_SAFE,
        WR_HUND,
        WR_OUT
    } wr_sel_t;

    // Step sequencing
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_OFF,
        JC_DIV_WAIT,
        JC_GOTO,
        JC_END
    } jump_t;

    localparam int PC_W = 5;

    typedef struct packed {
        mul_sel_t         mul;
        div_sel_t         div;
        wr_sel_t          wr;
        jump_t            jmp;
        logic [PC_W-1:0]  target;
    } ucode_t;

    localparam logic [PC_W-1:0] STEP_DIGITS = 5'd17;
    localparam logic [PC_W-1:0] STEP_SAFE   = 5'd19;
    localparam logic [PC_W-1:0] STEP_NONE   = 5'd0;

    function automatic ucode_t uw(input mul_sel_t m, input div_sel_t d, input wr_sel_t w,
                                  input jump_t j, input logic [PC_W-1:0] t);
        ucode_t u;
        u.mul    = m;
        u.div    = d;
        u.wr     = w;
        u.jmp    = j;
        u.target = t;
        return u;
    endfunction

    // Controller program: one control word per step
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] step);
        ucode_t u;
        case (step)
            5'd0:  u = uw(MS_NONE,    DS_NONE, WR_NONE,    JC_OFF,      STEP_SAFE);
            5'd1:  u = uw(MS_NONE,    DS_ERR,  WR_NONE,    JC_NEXT,     STEP_NONE);
            5'd2:  u = uw(MS_NONE,    DS_NONE, WR_NONE,    JC_DIV_WAIT, STEP_NONE);
            5'd3:  u = uw(MS_NONE,    DS_NONE, WR_ERR,     JC_NEXT,     STEP_NONE);
            5'd4:  u = uw(MS_ERR_PER, DS_DER,  WR_NONE,    JC_NEXT,     STEP_NONE);
            5'd5:  u = uw(MS_ERR_PG,  DS_NONE, WR_SUM,     JC_NEXT,     STEP_NONE);
            5'd6:  u = uw(MS_SUM_IG,  DS_NONE, WR_ACC_LD,  JC_NEXT,     STEP_NONE);
            5'd7:  u = uw(MS_NONE,    DS_NONE, WR_ACC_ADD, JC_NEXT,     STEP_NONE);
            5'd8:  u = uw(MS_NONE,    DS_NONE, WR_NONE,    JC_DIV_WAIT, STEP_NONE);
            5'd9:  u = uw(MS_NONE,    DS_NONE, WR_DER,     JC_NEXT,     STEP_NONE);
            5'd10: u = uw(MS_DER_DG,  DS_NONE, WR_NONE,    JC_NEXT,     STEP_NONE);
            5'd11: u = uw(MS_NONE,    DS_NONE, WR_ACC_ADD, JC_NEXT,     STEP_NONE);
            5'd12: u = uw(MS_NONE,    DS_NONE, WR_PID,     JC_NEXT,     STEP_NONE);
            5'd13: u = uw(MS_PID_K,   DS_NONE, WR_NONE,    JC_NEXT,     STEP_NONE);
            5'd14: u = uw(MS_NONE,    DS_NONE, WR_DEG,     JC_NEXT,     STEP_NONE);
            5'd15: u = uw(MS_DEG_SCL, DS_NONE, WR_NONE,    JC_NEXT,     STEP_NONE);
            5'd16: u = uw(MS_NONE,    DS_NONE, WR_PEDAL,   JC_NEXT,     STEP_NONE);
            5'd17: u = uw(MS_NONE,    DS_NONE, WR_HUND,    JC_NEXT,     STEP_NONE);
            5'd18: u = uw(MS_NONE,    DS_NONE, WR_OUT,     JC_END,      STEP_NONE);
            5'd19: u = uw(MS_NONE,    DS_NONE, WR_SAFE,    JC_GOTO,     STEP_DIGITS);
            default: u = uw(MS_NONE,  DS_NONE, WR_NONE,    JC_GOTO,     STEP_SAFE);
        endcase
        return u;
    endfunction

endpackage

FILE: sv/pidsp_div.sv
// Radix-4 restoring divider for unsigned magnitudes, two quotient bits per cycle.
module pidsp_div
    import pidsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVW-1:0]   dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVW-1:0]   quotient
);

    logic              busy_reg, busy_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVW-1:0]    quo_reg, quo_next;
    logic [DVS_W:0]    part0, part1, diff0, diff1;
    logic              ge0, ge1;
    logic [DVS_W-1:0]  rem_mid, rem_step;

    // Two compare-and-subtract stages per cycle
    always_comb
    begin
        part0    = {rem_reg, quo_reg[DVW-1]};
        diff0    = part0 - {1'b0, dvs_reg};
        ge0      = part0 >= {1'b0, dvs_reg};
        rem_mid  = ge0 ? diff0[DVS_W-1:0] : part0[DVS_W-1:0];
        part1    = {rem_mid, quo_reg[DVW-2]};
        diff1    = part1 - {1'b0, dvs_reg};
        ge1      = part1 >= {1'b0, dvs_reg};
        rem_step = ge1 ? diff1[DVS_W-1:0] : part1[DVS_W-1:0];
    end

    // Load on start, iterate while busy
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            quo_next = {quo_reg[DVW-3:0], ge0, ge1};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold divisor for the whole division
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/pid_speed_to_pedal_command.sv
// Top level of the PID speed controller that turns a speed error into pedal commands.
//
// Each input item carries an enable flag, desired and measured speed (signed Q8.8) and a
// path distance divisor; each item yields exactly one result item holding the accel and
// brake pedal values as three decimal digits each and the gear. A short microcoded
// program steers one shared multiplier and one radix-4 divider; an item is taken only
// while the program is idle. An enabled item holds the program from acceptance to the
// result: it waits on the error division (error over distance), then on the derivative
// division (error change over step period, which overlaps the multiply and accumulate
// steps), and runs the remaining steps; a disabled item skips the arithmetic steps. The
// next item is taken in the cycle after the result is loaded, so no item is taken
// before the last one is through the program. A finished result waits in the output
// register, and the block accepts the next item while it waits; the program stalls at
// its last step if the previous result has still not been taken. Gains, step period
// and pedal scales are to be written by the user over the configuration port only
// while idle; the block itself does not enforce this.
module pid_speed_to_pedal_command
    import pidsp_pkg::*;
#(
    parameter int PEDAL_MAX = 999
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // desired_speed [15:0], measured_speed [31:16], path_distance [47:32]
    input  logic [47:0]           s_axis_tdata,
    // enabled [0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // accel_hundreds [3:0], accel_tens [7:4], accel_ones [11:8], brake_hundreds [15:12],
    // brake_tens [19:16], brake_ones [23:20], gear_select [25:24], zero [31:26]
    output logic [31:0]           m_axis_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PED_W  = $clog2(PEDAL_MAX + 1);
    localparam int PRAW_W = PROD_W - 24;
    localparam int SAFE_BRAKE = (SAFE_BRAKE_RAW > PEDAL_MAX) ? PEDAL_MAX : SAFE_BRAKE_RAW;

    // Configuration registers
    logic signed [15:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [15:0]        step_period_reg, accel_scale_reg, brake_scale_reg;

    // Sequencer
    seq_state_t      seq_state_reg, seq_state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          uc;
    logic            in_accept, out_free, out_load, div_start;
    wr_sel_t         wr_sel;

    // Captured item
    logic              en_reg;
    logic signed [16:0] diff_reg;
    logic [15:0]       dist_reg;

    // Controller state
    logic signed [SUM_W-1:0] esum_reg, esum_next;
    logic signed [ERR_W-1:0] last_err_reg;
    logic [1:0]              gear_reg, gear_next;

    // Working registers
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [DER_W-1:0]  der_reg, der_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  pid_reg, pid_next, deg_reg, deg_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PED_W-1:0]         accel_reg, brake_reg, accel_next, brake_next;
    logic [3:0]               acc_h_reg, brk_h_reg;
    logic [6:0]               acc_rem_reg, brk_rem_reg;

    // Output register
    logic       out_valid_reg;
    logic [3:0] out_ah_reg, out_at_reg, out_ao_reg, out_bh_reg, out_bt_reg, out_bo_reg;
    logic [1:0] out_gear_reg;

    // Divider and multiplier operands
    logic                   div_busy;
    logic [DVW-1:0]         div_quo, div_dividend;
    logic [DVS_W-1:0]       div_divisor, per_eff;
    logic [16:0]            diff_mag;
    logic signed [DLT_W-1:0] dlt;
    logic [DLT_W-1:0]       dlt_mag;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic [32:0]            deg_mag;
    logic [15:0]            scale_sel;
    logic signed [ERR_W-1:0] q_err;
    logic signed [DER_W-1:0] q_der;
    logic [PRAW_W-1:0]      ped_raw;
    logic [PED_W-1:0]       ped_sat;
    logic [DIG_W-1:0]       acc_w, brk_w;
    logic [15:0]            acc_h_prod, brk_h_prod;
    logic [14:0]            acc_t_prod, brk_t_prod;
    logic [3:0]             acc_t, brk_t;

    function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] v,
                                                      input int unsigned sh);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
        return (v + bias) >>> sh;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = 32'(v);
        end
        return r;
    endfunction

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (seq_state_reg == SEQ_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign uc            = ucode_rom(pc_reg);

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
            deriv_gain_reg  <= DERIV_GAIN_RST;
            step_period_reg <= STEP_PERIOD_RST;
            accel_scale_reg <= ACCEL_SCALE_RST;
            brake_scale_reg <= BRAKE_SCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PROP_GAIN:   prop_gain_reg   <= $signed(cfg_data);
                REG_INTEG_GAIN:  integ_gain_reg  <= $signed(cfg_data);
                REG_DERIV_GAIN:  deriv_gain_reg  <= $signed(cfg_data);
                REG_STEP_PERIOD: step_period_reg <= cfg_data;
                REG_ACCEL_SCALE: accel_scale_reg <= cfg_data;
                REG_BRAKE_SCALE: brake_scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: next step and handshake strobes
    always_comb
    begin
        seq_state_next = seq_state_reg;
        pc_next        = pc_reg;
        out_load       = 1'b0;
        div_start      = 1'b0;
        out_free       = !out_valid_reg || m_axis_tready;
        case (seq_state_reg)
            SEQ_IDLE:
            begin
                if (in_accept)
                begin
                    seq_state_next = SEQ_RUN;
                    pc_next        = '0;
                end
            end
            SEQ_RUN:
            begin
                div_start = (uc.div != DS_NONE);
                case (uc.jmp)
                    JC_NEXT:     pc_next = pc_reg + 1'b1;
                    JC_OFF:      pc_next = en_reg ? pc_reg + 1'b1 : uc.target;
                    JC_DIV_WAIT:
                    begin
                        if (!div_busy)
                        begin
                            pc_next = pc_reg + 1'b1;
                        end
                    end
                    JC_GOTO:     pc_next = uc.target;
                    JC_END:
                    begin
                        if (out_free)
                        begin
                            out_load       = 1'b1;
                            seq_state_next = SEQ_IDLE;
                            pc_next        = '0;
                        end
                    end
                    default:     seq_state_next = SEQ_IDLE;
                endcase
            end
            default: seq_state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= SEQ_IDLE;
            pc_reg        <= '0;
        end
        else
        begin
            seq_state_reg <= seq_state_next;
            pc_reg        <= pc_next;
        end
    end

    assign wr_sel = (seq_state_reg == SEQ_RUN) ? uc.wr : WR_NONE;

    // Capture the item on accept
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            en_reg   <= s_axis_tuser;
            diff_reg <= 17'($signed(s_axis_tdata[15:0])) - 17'($signed(s_axis_tdata[31:16]));
            dist_reg <= (s_axis_tdata[47:32] == 16'd0) ? 16'd1 : s_axis_tdata[47:32];
        end
    end

    // Divider operands
    always_comb
    begin
        per_eff      = (step_period_reg == 16'd0) ? 16'd1 : step_period_reg;
        diff_mag     = diff_reg[16] ? 17'(-diff_reg) : 17'(diff_reg);
        dlt          = DLT_W'(err_reg) - DLT_W'(last_err_reg);
        dlt_mag      = dlt[DLT_W-1] ? DLT_W'(-dlt) : DLT_W'(dlt);
        if (uc.div == DS_DER)
        begin
            div_dividend = {dlt_mag, 12'b0};
            div_divisor  = per_eff;
        end
        else
        begin
            div_dividend = DVW'({diff_mag, 8'b0});
            div_divisor  = dist_reg;
        end
    end

    pidsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Shared multiplier operand select
    always_comb
    begin
        deg_mag   = deg_reg[SUM_W-1] ? (33'd0 - 33'(deg_reg)) : 33'(deg_reg);
        scale_sel = deg_reg[SUM_W-1] ? brake_scale_reg : accel_scale_reg;
        case (uc.mul)
            MS_ERR_PER:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = $signed(MB_W'(per_eff));
            end
            MS_ERR_PG:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = MB_W'(prop_gain_reg);
            end
            MS_SUM_IG:
            begin
                mul_a = MA_W'(esum_reg);
                mul_b = MB_W'(integ_gain_reg);
            end
            MS_DER_DG:
            begin
                mul_a = der_reg;
                mul_b = MB_W'(deriv_gain_reg);
            end
            MS_PID_K:
            begin
                mul_a = MA_W'(pid_reg);
                mul_b = DEG_PER_RAD;
            end
            MS_DEG_SCL:
            begin
                mul_a = $signed(MA_W'(deg_mag));
                mul_b = $signed(MB_W'(scale_sel));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Result arithmetic on the registered product and accumulator
    always_comb
    begin
        q_err     = $signed(ERR_W'(div_quo));
        q_der     = $signed(div_quo);
        err_next  = diff_reg[16] ? -q_err : q_err;
        der_next  = dlt[DLT_W-1] ? -q_der : q_der;
        esum_next = sat32(64'(esum_reg) + shr_trunc(64'(prod_reg), 12));
        pid_next  = sat32(shr_trunc(64'(acc_reg), 12));
        deg_next  = sat32(shr_trunc(64'(prod_reg), 16));
        ped_raw   = prod_reg[PROD_W-1:24];
        ped_sat   = (ped_raw > PRAW_W'(PEDAL_MAX)) ? PED_W'(PEDAL_MAX) : PED_W'(ped_raw);

        // Positive drives accel, negative drives brake, zero keeps the gear
        accel_next = '0;
        brake_next = '0;
        gear_next  = gear_reg;
        if (deg_reg[SUM_W-1])
        begin
            brake_next = ped_sat;
            gear_next  = GEAR_DRIVE;
        end
        else if (deg_reg != '0)
        begin
            accel_next = ped_sat;
            gear_next  = GEAR_DRIVE;
        end
    end

    // Controller state and pedal values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esum_reg     <= '0;
            last_err_reg <= '0;
            gear_reg     <= GEAR_PARK;
            accel_reg    <= '0;
            brake_reg    <= '0;
        end
        else
        begin
            case (wr_sel)
                WR_SUM:   esum_reg     <= esum_next;
                WR_PID:   last_err_reg <= err_reg;
                WR_PEDAL:
                begin
                    accel_reg <= accel_next;
                    brake_reg <= brake_next;
                    gear_reg  <= gear_next;
                end
                WR_SAFE:
                begin
                    accel_reg <= '0;
                    brake_reg <= PED_W'(SAFE_BRAKE);
                    gear_reg  <= GEAR_PARK;
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (wr_sel)
            WR_ERR:     err_reg <= err_next;
            WR_DER:     der_reg <= der_next;
            WR_ACC_LD:  acc_reg <= ACC_W'(prod_reg);
            WR_ACC_ADD: acc_reg <= acc_reg + ACC_W'(prod_reg);
            WR_PID:     pid_reg <= pid_next;
            WR_DEG:     deg_reg <= deg_next;
            default: ;
        endcase
    end

    // Decimal split: hundreds by reciprocal 41/4096, tens by 205/2048
    always_comb
    begin
        acc_w      = DIG_W'(accel_reg);
        brk_w      = DIG_W'(brake_reg);
        acc_h_prod = 16'(acc_w) * 16'd41;
        brk_h_prod = 16'(brk_w) * 16'd41;
        acc_t_prod = 15'(acc_rem_reg) * 15'd205;
        brk_t_prod = 15'(brk_rem_reg) * 15'd205;
        acc_t      = acc_t_prod[14:11];
        brk_t      = brk_t_prod[14:11];
    end

    always_ff @(posedge clk)
    begin
        if (wr_sel == WR_HUND)
        begin
            acc_h_reg   <= acc_h_prod[15:12];
            brk_h_reg   <= brk_h_prod[15:12];
            acc_rem_reg <= 7'(acc_w - DIG_W'(acc_h_prod[15:12]) * DIG_W'(100));
            brk_rem_reg <= 7'(brk_w - DIG_W'(brk_h_prod[15:12]) * DIG_W'(100));
        end
    end

    // Output register: load when the slot is free, drop on take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ah_reg   <= acc_h_reg;
            out_at_reg   <= acc_t;
            out_ao_reg   <= 4'(acc_rem_reg - 7'(acc_t) * 7'd10);
            out_bh_reg   <= brk_h_reg;
            out_bt_reg   <= brk_t;
            out_bo_reg   <= 4'(brk_rem_reg - 7'(brk_t) * 7'd10);
            out_gear_reg <= gear_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_gear_reg, out_bo_reg, out_bt_reg, out_bh_reg,
                            out_ao_reg, out_at_reg, out_ah_reg};

    // The program never launches a division on a busy divider
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("division launched while divider busy");

    // Gear only ever holds park or drive
    a_gear_legal: assert property (@(posedge clk) disable iff (!rst_n)
        gear_reg == GEAR_PARK || gear_reg == GEAR_DRIVE)
        else $error("gear register holds an illegal code");

    // A disabled item leaves the integral untouched
    a_sum_held_off: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_state_reg == SEQ_RUN && !en_reg) |=> $stable(esum_reg))
        else $error("integral changed on a disabled item");

endmodule
